FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked implication checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted set table: same-cycle check failed");

// next-cycle implication
`define SST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted set table: next-cycle check failed");

`endif

FILE: design/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes of the sorted set table
// Command, status and cell update codes plus the cell control struct.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SST_CAPACITY = 32;

    // request command codes
    localparam logic [2:0] CMD_INSERT       = 3'd0;
    localparam logic [2:0] CMD_REMOVE_VALUE = 3'd1;
    localparam logic [2:0] CMD_SEARCH       = 3'd2;
    localparam logic [2:0] CMD_REMOVE_POS   = 3'd3;
    localparam logic [2:0] CMD_CLEAR        = 3'd4;

    // response status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    // cell update codes
    localparam logic [1:0] UPD_HOLD   = 2'd0;
    localparam logic [1:0] UPD_INSERT = 2'd1;
    localparam logic [1:0] UPD_DROP   = 2'd2;

    // control broadcast to every cell
    typedef struct packed {
        logic               scan_en;
        logic [1:0]         upd;
        logic signed [31:0] key;
    } t_cell_ctl;

endpackage

FILE: design/sorted_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table: ordered set of distinct signed 32-bit values
// Chain of compare-and-shift cells with a small command sequencer.
// ----------------------------------------------------------------------------
// After a request is accepted, the match and rank tally ripples one cell per
// cycle down the chain in the scan state; then, in the apply state, every
// cell shifts in parallel and the response register loads. The block is
// ready again the cycle after the response is loaded, even while that
// response still waits on the output, but it takes no new request while one
// is still in the scan or apply state. A response left waiting holds the
// following request in its apply cycle until the output takes the waiting
// one. Searches report 1-based positions; remove by position uses 1-based
// positions as well.
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [2:0]        i_command,
    input  logic signed [31:0] i_value,
    input  logic [5:0]        i_position,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [1:0]        o_status,
    output logic [5:0]        o_found_position,
    output logic [5:0]        o_entry_count
);

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [SW-1:0] SCAN_LAST = SW'(CAPACITY - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [SW-1:0]       r_scan_cnt;
    logic [2:0]          r_cmd;
    logic signed [31:0]  r_key;
    logic [5:0]          r_pos;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_rsp_valid;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic [5:0]          r_found;
    logic [5:0]          n_found;

    logic                w_req_fire;
    logic                w_apply_fire;
    logic                w_hit;
    logic [CW-1:0]       w_less;
    logic [1:0]          w_upd;
    logic [CW-1:0]       w_idx;
    logic [CW+5:0]       w_pos_x;
    logic [CW+5:0]       w_cnt_x;
    logic [CW+5:0]       w_pos_m1;
    logic [CW+5:0]       w_found_x;
    logic [CW+5:0]       w_count_x;
    t_cell_ctl           w_ctl;

    logic signed [31:0]  w_entry [CAPACITY];
    logic                w_hit_c [CAPACITY];
    logic [CW-1:0]       w_less_c [CAPACITY];

    // handshakes
    assign o_req_ready  = (r_state == S_IDLE);
    assign w_req_fire   = i_req_valid && o_req_ready;
    assign w_apply_fire = (r_state == S_APPLY) && (!r_rsp_valid || i_rsp_ready);

    // tally at the end of the chain
    assign w_hit  = w_hit_c[CAPACITY-1];
    assign w_less = w_less_c[CAPACITY-1];

    // widened position and count
    assign w_pos_x   = {{CW{1'b0}}, r_pos};
    assign w_cnt_x   = {6'b0, r_count};
    assign w_pos_m1  = w_pos_x - 1'b1;
    assign w_found_x = {6'b0, w_less} + 1'b1;

    // command decode for the apply cycle
    always_comb begin
        n_status = ST_MISS;
        n_found  = 6'd0;
        n_count  = r_count;
        w_upd    = UPD_HOLD;
        w_idx    = w_less;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (w_hit) begin
                    n_status = ST_PRESENT;
                end else if (r_count >= CAP_C) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    w_upd    = UPD_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_REMOVE_VALUE: begin
                if (w_hit) begin
                    n_status = ST_DONE;
                    w_upd    = UPD_DROP;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (w_hit) begin
                    n_status = ST_DONE;
                    n_found  = w_found_x[5:0];
                end
            end
            CMD_REMOVE_POS: begin
                w_idx = w_pos_m1[CW-1:0];
                if ((r_pos != 6'd0) && (w_pos_x <= w_cnt_x)) begin
                    n_status = ST_DONE;
                    w_upd    = UPD_DROP;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_status = ST_DONE;
                n_count  = '0;
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // control broadcast to the chain
    assign w_ctl.scan_en = (r_state == S_SCAN);
    assign w_ctl.upd     = w_apply_fire ? w_upd : UPD_HOLD;
    assign w_ctl.key     = r_key;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        logic               w_hit_in;
        logic [CW-1:0]      w_less_in;

        if (g == 0) begin : g_first
            assign w_left    = r_key;
            assign w_hit_in  = 1'b0;
            assign w_less_in = '0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_hit_in  = w_hit_c[g-1];
            assign w_less_in = w_less_c[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = 32'sd0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sst_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_idx         (w_idx),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_hit         (w_hit_in),
            .i_less        (w_less_in),
            .o_entry       (w_entry[g]),
            .o_hit         (w_hit_c[g]),
            .o_less        (w_less_c[g])
        );
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_apply_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end else begin
                r_scan_cnt <= '0;
            end
            if (w_apply_fire) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // request and response payload
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_cmd <= i_command;
            r_key <= i_value;
            r_pos <= i_position;
        end
        if (w_apply_fire) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    // outputs
    assign w_count_x        = {6'b0, r_count};
    assign o_rsp_valid      = r_rsp_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_entry_count    = w_count_x[5:0];

    // checks
    `SST_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_C)
    `SST_ASSERT_NXT(a_scan_to_apply, i_clk, i_rst_n,
        (r_state == S_SCAN) && (r_scan_cnt == SCAN_LAST), r_state == S_APPLY)
    `SST_ASSERT_NXT(a_insert_count, i_clk, i_rst_n,
        w_apply_fire && (r_cmd == CMD_INSERT) && (n_status == ST_DONE),
        r_count == $past(r_count) + 1'b1)
    `SST_ASSERT_IMP(a_found_done, i_clk, i_rst_n,
        o_rsp_valid && (o_found_position != 6'd0), o_status == ST_DONE)

endmodule

FILE: design/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted set chain
// Holds one entry, compares it with the request key, adds its share to the
// rank/match tally passed along the chain, and shifts entries on update.
// ----------------------------------------------------------------------------
module sst_cell
    import sst_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 6
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [CW-1:0]      i_idx,
    input  logic signed [31:0] i_left_entry,
    input  logic signed [31:0] i_right_entry,
    input  logic               i_hit,
    input  logic [CW-1:0]      i_less,
    output logic signed [31:0] o_entry,
    output logic               o_hit,
    output logic [CW-1:0]      o_less
);

    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic signed [31:0] r_entry;
    logic               r_hit;
    logic [CW-1:0]      r_less;
    logic signed [31:0] w_key;
    logic               w_valid;
    logic               w_lt;
    logic               w_eq;

    // local compare against the key
    assign w_key   = i_ctl.key;
    assign w_valid = IDX_C < i_count;
    assign w_lt    = w_valid && (r_entry < w_key);
    assign w_eq    = w_valid && (r_entry == w_key);

    // tally of matches and smaller entries, one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_en) begin
            r_hit  <= i_hit | w_eq;
            r_less <= i_less + CW'(w_lt);
        end
    end

    // entry shift on insert or removal
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.upd)
            UPD_INSERT: begin
                if (IDX_C == i_idx) begin
                    r_entry <= w_key;
                end else if (IDX_C > i_idx) begin
                    r_entry <= i_left_entry;
                end
            end
            UPD_DROP: begin
                if (IDX_C >= i_idx) begin
                    r_entry <= i_right_entry;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_less  = r_less;

endmodule

FILE: tb/tb_sorted_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_table: self-checking bench for the sorted set table
// Directed table first, then random fill, churn and drain sequences.
// Responses not typed in the table are checked by a behavioral set model.
// Both handshakes idle at random, and the output is held off once for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_sorted_set_table;
    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int ITEM_TARGET = 1700;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 250;
    localparam int DIR_ROWS    = 25;

    // command codes the block treats as no-ops
    localparam logic [2:0] CMD_RESERVED_5 = 3'd5;
    localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
    localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_pos;
        logic [5:0] count;
    } t_set_rsp;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] val;
        logic [5:0]         pos;
        bit                 has_rsp;
        t_set_rsp           rsp;
    } t_dir_row;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_req_valid      = 1'b0;
    logic [2:0]        i_command        = CMD_CLEAR;
    logic signed [31:0] i_value         = '0;
    logic [5:0]        i_position       = '0;
    logic              i_rsp_ready      = 1'b0;
    logic              o_req_ready;
    logic              o_rsp_valid;
    logic [1:0]        o_status;
    logic [5:0]        o_found_position;
    logic [5:0]        o_entry_count;

    // set model state
    logic signed [31:0] set_vals [SST_CAPACITY];
    int                 set_count = 0;
    t_set_rsp           expected_rsps [$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  rsps_checked   = 0;
    int  full_refusals  = 0;
    int  dup_inserts    = 0;
    int  miss_count     = 0;
    int  times_filled   = 0;
    int  hold_left      = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    // directed rows; typed responses only where they are obvious
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_SEARCH,       32'sd0,        6'd0,  1'b1, '{ST_MISS,    6'd0, 6'd0}},
        '{CMD_REMOVE_VALUE, 32'sd5,        6'd0,  1'b1, '{ST_MISS,    6'd0, 6'd0}},
        '{CMD_REMOVE_POS,   32'sd0,        6'd1,  1'b1, '{ST_MISS,    6'd0, 6'd0}},
        '{CMD_INSERT,       VAL_MIN,       6'd0,  1'b1, '{ST_DONE,    6'd0, 6'd1}},
        '{CMD_INSERT,       VAL_MAX,       6'd0,  1'b1, '{ST_DONE,    6'd0, 6'd2}},
        '{CMD_INSERT,       32'sd0,        6'd0,  1'b1, '{ST_DONE,    6'd0, 6'd3}},
        '{CMD_INSERT,       VAL_MAX,       6'd0,  1'b1, '{ST_PRESENT, 6'd0, 6'd3}},
        '{CMD_SEARCH,       VAL_MIN,       6'd0,  1'b1, '{ST_DONE,    6'd1, 6'd3}},
        '{CMD_SEARCH,       VAL_MAX,       6'd0,  1'b1, '{ST_DONE,    6'd3, 6'd3}},
        '{CMD_INSERT,       -32'sd1,       6'd0,  1'b0, '0},
        '{CMD_INSERT,       32'sh5555_5555, 6'd0, 1'b0, '0},
        '{CMD_INSERT,       32'shaaaa_aaaa, 6'd0, 1'b0, '0},
        '{CMD_SEARCH,       32'sd0,        6'd0,  1'b0, '0},
        '{CMD_REMOVE_POS,   32'sd0,        6'd0,  1'b1, '{ST_MISS,    6'd0, 6'd6}},
        '{CMD_REMOVE_POS,   32'sd0,        6'd63, 1'b1, '{ST_MISS,    6'd0, 6'd6}},
        '{CMD_REMOVE_POS,   32'sd0,        6'd7,  1'b1, '{ST_MISS,    6'd0, 6'd6}},
        '{CMD_REMOVE_POS,   32'sd0,        6'd6,  1'b1, '{ST_DONE,    6'd0, 6'd5}},
        '{CMD_REMOVE_VALUE, VAL_MIN,       6'd0,  1'b1, '{ST_DONE,    6'd0, 6'd4}},
        '{CMD_RESERVED_5,   32'sd1,        6'd1,  1'b1, '{ST_MISS,    6'd0, 6'd4}},
        '{CMD_RESERVED_6,   32'sd0,        6'd0,  1'b1, '{ST_MISS,    6'd0, 6'd4}},
        '{CMD_RESERVED_7,   -32'sd1,       6'd63, 1'b1, '{ST_MISS,    6'd0, 6'd4}},
        '{CMD_SEARCH,       32'sd12345,    6'd0,  1'b0, '0},
        '{CMD_REMOVE_VALUE, -32'sd1,       6'd0,  1'b0, '0},
        '{CMD_CLEAR,        32'sd0,        6'd0,  1'b1, '{ST_DONE,    6'd0, 6'd0}},
        '{CMD_REMOVE_POS,   32'sd0,        6'd1,  1'b1, '{ST_MISS,    6'd0, 6'd0}}
    };

    sorted_set_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_ready      (i_rsp_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_rsps.size());
        $display("Mismatches found");
        $finish;
    end

    // first slot whose value is not below key
    function automatic int find_slot(input logic signed [31:0] key, output bit hit);
        int i;
        hit = 1'b0;
        for (i = 0; i < set_count; i++) begin
            if (set_vals[i] == key) begin
                hit = 1'b1;
                return i;
            end
            if (set_vals[i] > key) return i;
        end
        return set_count;
    endfunction

    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i < set_count - 1; i++) set_vals[i] = set_vals[i + 1];
        set_count--;
    endfunction

    // apply one command to the set model and return its response
    function automatic t_set_rsp apply_set_command(input logic [2:0] cmd,
                                                   input logic signed [31:0] val,
                                                   input logic [5:0] pos);
        t_set_rsp rsp;
        int       idx;
        int       i;
        bit       hit;
        rsp.status    = ST_MISS;
        rsp.found_pos = '0;
        case (cmd)
            CMD_INSERT: begin
                idx = find_slot(val, hit);
                if (hit) begin
                    rsp.status = ST_PRESENT;
                end else if (set_count >= SST_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = set_count; i > idx; i--) set_vals[i] = set_vals[i - 1];
                    set_vals[idx] = val;
                    set_count++;
                    rsp.status = ST_DONE;
                end
            end
            CMD_REMOVE_VALUE: begin
                idx = find_slot(val, hit);
                if (hit) begin
                    drop_entry(idx);
                    rsp.status = ST_DONE;
                end
            end
            CMD_SEARCH: begin
                idx = find_slot(val, hit);
                if (hit) begin
                    rsp.found_pos = 6'(idx + 1);
                    rsp.status    = ST_DONE;
                end
            end
            CMD_REMOVE_POS: begin
                if (pos != 0 && int'(pos) <= set_count) begin
                    drop_entry(int'(pos) - 1);
                    rsp.status = ST_DONE;
                end
            end
            CMD_CLEAR: begin
                set_count  = 0;
                rsp.status = ST_DONE;
            end
            default: ;
        endcase
        rsp.count = 6'(set_count);
        return rsp;
    endfunction

    // offer one request, wait for acceptance, then queue its response
    task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] val,
                                input logic [5:0] pos, input bit has_rsp,
                                input t_set_rsp fixed_rsp);
        t_set_rsp rsp;
        if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
        end
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_command   <= cmd;
        i_value     <= val;
        i_position  <= pos;
        do @(posedge i_clk); while (!o_req_ready);
        rsp = apply_set_command(cmd, val, pos);
        if (has_rsp) rsp = fixed_rsp;
        expected_rsps.push_back(rsp);
        items_sent++;
        if (cmd == CMD_INSERT && rsp.status == ST_DONE && rsp.count == SST_CAPACITY)
            times_filled++;
        if (rsp.status == ST_FULL) full_refusals++;
        if (rsp.status == ST_PRESENT) dup_inserts++;
        if (rsp.status == ST_MISS) miss_count++;
    endtask

    task automatic send_random(input logic [2:0] cmd, input logic signed [31:0] val,
                               input logic [5:0] pos);
        send_request(cmd, val, pos, 1'b0, '0);
    endtask

    // hold new requests until every response is back
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (expected_rsps.size() != 0);
    endtask

    // value mix: held entries, a narrow band around zero, extremes, anything
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3 && set_count > 0) begin
            v = set_vals[$urandom_range(0, set_count - 1)];
        end else if (sel <= 5) begin
            v = $urandom_range(0, 64);
            v = v - 32;
        end else if (sel == 6) begin
            v = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic logic [5:0] pick_position();
        if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, set_count + 1));
    endfunction

    // response check against the oldest expectation
    task automatic check_response();
        t_set_rsp exp_rsp;
        if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: response with no request outstanding: status %0d pos %0d count %0d",
                         $realtime, o_status, o_found_position, o_entry_count);
        end else begin
            exp_rsp = expected_rsps.pop_front();
            rsps_checked++;
            if (o_status !== exp_rsp.status || o_found_position !== exp_rsp.found_pos ||
                o_entry_count !== exp_rsp.count) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: response %0d: status %0d/%0d pos %0d/%0d count %0d/%0d (exp/got)",
                             $realtime, rsps_checked, exp_rsp.status, o_status,
                             exp_rsp.found_pos, o_found_position, exp_rsp.count, o_entry_count);
            end
        end
    endtask

    // response side: check, then pick ready for the next cycle
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && i_rsp_ready) check_response();
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_rsp_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4) - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // request side
    initial begin
        int  r;
        int  n;
        int  guard;
        int  kind;
        int  w;
        bit  hold_done;
        bit  pause_done;
        logic [2:0] cmd;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
            send_request(dir_rows[r].cmd, dir_rows[r].val, dir_rows[r].pos,
                         dir_rows[r].has_rsp, dir_rows[r].rsp);
        wait_drained();

        // random sequences
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 500) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 1000) begin
                wait_drained();
                pause_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                // fill to capacity, then duplicate and overflow inserts
                if ($urandom_range(0, 1)) send_random(CMD_CLEAR, $urandom, 6'($urandom));
                guard = 0;
                while (set_count < SST_CAPACITY && guard < 100) begin
                    send_random(CMD_INSERT,
                                $urandom_range(0, 3) == 0 ? pick_value() : $urandom,
                                6'($urandom));
                    guard++;
                end
                n = $urandom_range(1, 3);
                repeat (n) send_random(CMD_INSERT, pick_value(), 6'($urandom));
            end else if (kind <= 4) begin
                // empty the set, then poke at the empty set
                guard = 0;
                while (set_count > 0 && guard < 100) begin
                    if ($urandom_range(0, 1))
                        send_random(CMD_REMOVE_POS, $urandom, 6'($urandom_range(1, set_count)));
                    else
                        send_random(CMD_REMOVE_VALUE, set_vals[$urandom_range(0, set_count - 1)],
                                    6'($urandom));
                    guard++;
                end
                n = $urandom_range(1, 2);
                repeat (n) send_random($urandom_range(0, 1) ? CMD_REMOVE_POS : CMD_REMOVE_VALUE,
                                       pick_value(), 6'($urandom));
            end else if (kind <= 8) begin
                // mixed traffic
                n = $urandom_range(20, 40);
                repeat (n) begin
                    w = $urandom_range(0, 99);
                    if (w < 35)      cmd = CMD_INSERT;
                    else if (w < 50) cmd = CMD_REMOVE_VALUE;
                    else if (w < 72) cmd = CMD_SEARCH;
                    else if (w < 90) cmd = CMD_REMOVE_POS;
                    else if (w < 93) cmd = CMD_CLEAR;
                    else if (w < 95) cmd = CMD_RESERVED_5;
                    else if (w < 97) cmd = CMD_RESERVED_6;
                    else             cmd = CMD_RESERVED_7;
                    send_random(cmd, pick_value(), pick_position());
                end
            end else begin
                // raw field noise
                n = $urandom_range(3, 6);
                repeat (n) send_random(3'($urandom), $urandom, 6'($urandom));
            end
        end

        wait_drained();
        repeat (SST_CAPACITY + 8) @(posedge i_clk);
        mismatch_count += expected_rsps.size();

        $display("%0d requests sent, %0d responses checked, set filled %0d times",
                 items_sent, rsps_checked, times_filled);
        $display("%0d full refusals, %0d duplicate inserts, %0d misses or bad positions",
                 full_refusals, dup_inserts, miss_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
